[rtl/mrr_pkg.sv]
// Shared constants and types for the Miller-Rabin round block.
`timescale 1ns / 1ps
`default_nettype none
package mrr_pkg;
	localparam int WIDTH = 64;
	localparam int CNT_W = $clog2(WIDTH + 1);

	// Operands and modulus handed to the modular multiplier.
	typedef struct packed {
		logic [WIDTH-1:0] a;
		logic [WIDTH-1:0] b;
		logic [WIDTH-1:0] n;
	} mul_req_t;
endpackage
`default_nettype wire

[rtl/mrr_mulmod.sv]
// Bit-serial shift-add modular multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mrr_mulmod import mrr_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire mul_req_t         req,
	output logic                  done,
	output logic [WIDTH-1:0]      result
);
	logic [WIDTH-1:0] a_q, b_q, n_q, r_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [WIDTH:0]   dbl, dbl_red, add;
	logic [WIDTH-1:0] r_dbl, r_next;

	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= {1'b0, n_q}) ? dbl - {1'b0, n_q} : dbl;
		r_dbl   = dbl_red[WIDTH-1:0];
		add     = {1'b0, r_dbl} + {1'b0, a_q};
		if (b_q[WIDTH-1]) begin
			r_next = (add >= {1'b0, n_q}) ? WIDTH'(add - {1'b0, n_q}) : add[WIDTH-1:0];
		end else begin
			r_next = r_dbl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= req.a;
			b_q <= req.b;
			n_q <= req.n;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= r_next;
			b_q <= {b_q[WIDTH-2:0], 1'b0};
		end
	end

	assign result = r_q;
endmodule
`default_nettype wire

[rtl/miller_rabin_round.sv]
// Top level of the Miller-Rabin round: control sequencer and stream ports.
`timescale 1ns / 1ps
`default_nettype none
// One Miller-Rabin round per transfer. Candidate n and witness a arrive on the
// slave stream; one verdict leaves on the master stream. Candidates 0, 1, 4 are
// composite and 2, 3 prime; these skip the multiplier and set decided_trivially.
// Otherwise the witness is reduced mod n (one bit per cycle), n-1 is split into
// d*2^s by shifting one bit per cycle, a^d mod n is formed by right-to-left
// square-and-multiply, then up to s-1 squarings follow. Every modular product
// runs through one shared bit-serial multiplier; a round needs up to about
// 2*WIDTH products. One item is in work at a time; the input side opens again
// only once the previous verdict has transferred.
module miller_rabin_round import mrr_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [127:0] s_axis_tdata,  // candidate [63:0], witness [127:64]
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [7:0]        m_axis_tdata   // probably_prime [0], decided_trivially [1]
);
	typedef enum logic [3:0] {
		S_IDLE, S_RED, S_SPLIT, S_POW, S_MUL_ACC, S_MUL_SQ, S_CHECK, S_SQ, S_SQ_W, S_OUT
	} state_t;

	state_t           state_q;
	logic [WIDTH-1:0] n_q, nm1_q, a_q, d_q, acc_q, base_q, rem_q;
	logic [CNT_W-1:0] s_q, cnt_q, i_q;
	logic             prime_q, triv_q;
	logic             mul_start;
	mul_req_t         mul_req;
	logic             mul_done;
	logic [WIDTH-1:0] mul_res;
	logic [WIDTH:0]   rem_sh;
	logic [WIDTH-1:0] n_in, a_in;

	assign n_in = s_axis_tdata[WIDTH-1:0];
	assign a_in = s_axis_tdata[64 +: WIDTH];
	assign s_axis_tready = (state_q == S_IDLE) && !m_axis_tvalid;
	assign rem_sh = {rem_q, a_q[WIDTH-1]};

	mrr_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.req    (mul_req),
		.done   (mul_done),
		.result (mul_res)
	);

	always_comb begin
		mul_start = 1'b0;
		mul_req   = '{a: acc_q, b: base_q, n: n_q};
		unique case (state_q)
			S_POW: begin
				mul_start = (d_q != '0);
				if (d_q[0]) mul_req = '{a: acc_q, b: base_q, n: n_q};
				else        mul_req = '{a: base_q, b: base_q, n: n_q};
			end
			S_MUL_ACC: begin
				// start the squaring of the base once the accumulate finishes
				mul_start = mul_done;
				mul_req   = '{a: base_q, b: base_q, n: n_q};
			end
			S_SQ: begin
				mul_start = 1'b1;
				mul_req   = '{a: acc_q, b: acc_q, n: n_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			n_q           <= '0;
			nm1_q         <= '0;
			a_q           <= '0;
			d_q           <= '0;
			acc_q         <= '0;
			base_q        <= '0;
			rem_q         <= '0;
			s_q           <= '0;
			cnt_q         <= '0;
			i_q           <= '0;
			prime_q       <= 1'b0;
			triv_q        <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					// 2 and 3 only ever appear on the small-value path
					triv_q  <= (n_in <= WIDTH'(4));
					prime_q <= (n_in == WIDTH'(2)) || (n_in == WIDTH'(3));
					n_q    <= n_in;
					nm1_q  <= n_in - 1'b1;
					d_q    <= n_in - 1'b1;
					a_q    <= a_in;
					rem_q  <= '0;
					s_q    <= '0;
					cnt_q  <= CNT_W'(WIDTH);
					if (n_in <= WIDTH'(4)) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_RED;
					end
				end
				S_RED: begin
					// restoring reduction of the witness, one bit per cycle
					rem_q <= (rem_sh >= {1'b0, n_q}) ? WIDTH'(rem_sh - {1'b0, n_q})
					                                 : rem_sh[WIDTH-1:0];
					a_q   <= {a_q[WIDTH-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) state_q <= S_SPLIT;
				end
				S_SPLIT: begin
					base_q <= rem_q;
					acc_q  <= WIDTH'(1);
					if (!d_q[0]) begin
						d_q <= d_q >> 1;
						s_q <= s_q + 1'b1;
					end else begin
						state_q <= S_POW;
					end
				end
				S_POW: begin
					if (d_q == '0)      state_q <= S_CHECK;
					else if (d_q[0])    state_q <= S_MUL_ACC;
					else                state_q <= S_MUL_SQ;
					i_q <= CNT_W'(1);
				end
				S_MUL_ACC: if (mul_done) begin
					acc_q   <= mul_res;
					state_q <= S_MUL_SQ;
				end
				S_MUL_SQ: if (mul_done) begin
					base_q  <= mul_res;
					d_q     <= d_q >> 1;
					state_q <= S_POW;
				end
				S_CHECK: begin
					if (acc_q == WIDTH'(1) || acc_q == nm1_q) begin
						prime_q <= 1'b1;
						state_q <= S_OUT;
					end else if (i_q >= s_q) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_SQ;
					end
				end
				S_SQ: state_q <= S_SQ_W;
				S_SQ_W: if (mul_done) begin
					acc_q <= mul_res;
					i_q   <= i_q + 1'b1;
					// a squaring that reaches 1 ends the round as composite
					if (mul_res == WIDTH'(1))   state_q <= S_OUT;
					else if (mul_res == nm1_q) begin
						prime_q <= 1'b1;
						state_q <= S_OUT;
					end else if (i_q + 1'b1 >= s_q) state_q <= S_OUT;
					else state_q <= S_SQ;
				end
				S_OUT: if (!m_axis_tvalid) begin
					m_axis_tvalid <= 1'b1;
					m_axis_tdata  <= {6'b0, triv_q, prime_q};
					state_q       <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
